// ===== design/lgs_pkg.sv =====
// shared types and constants for the toroidal life grid block
`default_nettype none

package lgs_pkg;

   // command codes carried in the request word
   typedef enum logic [1:0] {
      CMD_TOGGLE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_STEP   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL,
      ST_LOAD_CUR,
      ST_LOAD_NXT,
      ST_ROW,
      ST_DONE
   } state_type;

   // width of the row and column fields in the request word
   localparam int unsigned IDX_FIELD_W = 6;

   // neighbor count width and the life rule thresholds
   localparam int unsigned NBR_CNT_W   = 4;
   localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_CNT_W-1:0] KEEP_COUNT  = 4'd2;

endpackage

`default_nettype wire

// ===== design/life_grid_generation_step.sv =====
// top level: toroidal life grid with toggle, clear, step and read commands
//
//   channel  direction  ports                                  handshake
//   req      in         req_command, req_row, req_col          req_valid / req_stall
//   rsp      out        rsp_command_echo, rsp_cell_alive       rsp_valid / rsp_stall
//
// a step runs one row of the grid per cycle through the shared
// row rule unit, bounded by the single read and single write port of the row memory.
// toggle and read go through row read, bit update and result load; clear goes to result load.
// one word is in flight at a time; req_stall is high until the result is handed over.
// the result register lets a new word be taken while the previous result waits.
// reset and clear kill the grid at once through per-row valid bits, no clearing pass.
`default_nettype none

module life_grid_generation_step #(
   parameter int unsigned GRID_SIZE = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [5:0] req_row,
   input  wire logic [5:0] req_col,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [1:0] rsp_command_echo,
   output logic            rsp_cell_alive
);
   import lgs_pkg::*;

   localparam int unsigned ROW_W = $clog2(GRID_SIZE);
   localparam int unsigned CMP_W = ((ROW_W > IDX_FIELD_W) ? ROW_W : IDX_FIELD_W) + 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);

   state_type state_ff, state_in;

   cmd_type              req_cmd;
   logic                 req_inside;
   cmd_type              cmd_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [ROW_W-1:0]     col_ff;
   logic                 inside_ff;
   logic                 alive_ff;
   logic [ROW_W-1:0]     r_ff;
   logic [ROW_W:0]       r_plus2;
   logic [GRID_SIZE-1:0] up_ff;
   logic [GRID_SIZE-1:0] cur_ff;
   logic [GRID_SIZE-1:0] first_ff;
   logic [GRID_SIZE-1:0] dn_row;
   logic [GRID_SIZE-1:0] nxt_row;
   logic [GRID_SIZE-1:0] flip_mask;
   logic                 cell_bit;

   logic                 mem_clear;
   logic                 mem_rd_en;
   logic [ROW_W-1:0]     mem_rd_addr;
   logic [GRID_SIZE-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [ROW_W-1:0]     mem_wr_addr;
   logic [GRID_SIZE-1:0] mem_wr_data;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_command_echo_ff;
   logic                 rsp_cell_alive_ff;
   logic                 rsp_free;

   // request decode
   assign req_cmd    = cmd_type'(req_command);
   assign req_inside = (CMP_W'(req_row) < CMP_W'(GRID_SIZE))
                    && (CMP_W'(req_col) < CMP_W'(GRID_SIZE));
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // row sweep helpers
   assign r_plus2   = (ROW_W + 1)'(r_ff) + (ROW_W + 1)'(2);
   assign dn_row    = (r_ff == LAST_ROW) ? first_ff : mem_rd_data;
   assign flip_mask = GRID_SIZE'(1) << col_ff;
   assign cell_bit  = inside_ff ? mem_rd_data[col_ff] : 1'b0;

   lgs_row_mem #(
      .GRID_SIZE (GRID_SIZE)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   lgs_row_rule #(
      .GRID_SIZE (GRID_SIZE)
   ) u_rule (
      .up_row  (up_ff),
      .cur_row (cur_ff),
      .dn_row  (dn_row),
      .nxt_row (nxt_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_TOGGLE, CMD_READ: state_in = ST_CELL;
                  CMD_CLEAR:            state_in = ST_DONE;
                  CMD_STEP:             state_in = ST_LOAD_CUR;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_CELL:     state_in = ST_DONE;
         ST_LOAD_CUR: state_in = ST_LOAD_NXT;
         ST_LOAD_NXT: state_in = ST_ROW;
         ST_ROW: begin
            if (r_ff == LAST_ROW) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      mem_clear   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_TOGGLE, CMD_READ: begin
                     mem_rd_en   = req_inside;
                     mem_rd_addr = ROW_W'(req_row);
                  end
                  CMD_CLEAR: mem_clear = 1'b1;
                  CMD_STEP: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = LAST_ROW;
                  end
                  default: mem_clear = 1'b0;
               endcase
            end
         end
         ST_CELL: begin
            mem_wr_en   = (cmd_ff == CMD_TOGGLE) && inside_ff;
            mem_wr_addr = row_ff;
            mem_wr_data = mem_rd_data ^ flip_mask;
         end
         ST_LOAD_CUR: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
         end
         ST_LOAD_NXT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ROW_W'(1);
         end
         ST_ROW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_ff;
            mem_wr_data = nxt_row;
            mem_rd_en   = r_plus2 < (ROW_W + 1)'(GRID_SIZE);
            mem_rd_addr = r_plus2[ROW_W-1:0];
         end
         ST_DONE: mem_clear = 1'b0;
         default: mem_clear = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOAD_NXT) begin
            r_ff <= '0;
         end else if (state_ff == ST_ROW && r_ff != LAST_ROW) begin
            r_ff <= r_ff + ROW_W'(1);
         end
      end
   end

   // command word and row buffers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_ff    <= req_cmd;
               row_ff    <= ROW_W'(req_row);
               col_ff    <= ROW_W'(req_col);
               inside_ff <= req_inside;
               alive_ff  <= 1'b0;
            end
         end
         ST_CELL: begin
            alive_ff <= inside_ff && ((cmd_ff == CMD_TOGGLE) ? !cell_bit : cell_bit);
         end
         ST_LOAD_CUR: up_ff <= mem_rd_data;
         ST_LOAD_NXT: begin
            cur_ff   <= mem_rd_data;
            first_ff <= mem_rd_data;
         end
         ST_ROW: begin
            up_ff  <= cur_ff;
            cur_ff <= dn_row;
         end
         ST_DONE: alive_ff <= alive_ff;
         default: alive_ff <= alive_ff;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_command_echo_ff <= cmd_ff;
         rsp_cell_alive_ff   <= alive_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_echo = rsp_command_echo_ff;
   assign rsp_cell_alive   = rsp_cell_alive_ff;

   // a new result only comes out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result word raised outside done state");

   // clear and step words never report a live cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_command_echo_ff == CMD_CLEAR || rsp_command_echo_ff == CMD_STEP)
      |-> !rsp_cell_alive_ff)
      else $error("clear or step word reports a live cell");

   // the grid is never written while idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_wr_en)
      else $error("grid write while idle");

   // the row sweep starts from row zero
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD_NXT |=> state_ff == ST_ROW && r_ff == '0)
      else $error("row sweep did not start at row zero");

endmodule

`default_nettype wire

// ===== design/lgs_row_mem.sv =====
// row-wide grid memory with per-row valid bits, one write and one registered read port
`default_nettype none

module lgs_row_mem #(
   parameter int unsigned GRID_SIZE = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(GRID_SIZE)-1:0] rd_addr,
   output logic      [GRID_SIZE-1:0]         rd_data,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(GRID_SIZE)-1:0] wr_addr,
   input  wire logic [GRID_SIZE-1:0]         wr_data
);

   logic [GRID_SIZE-1:0] mem_ff [GRID_SIZE];
   logic [GRID_SIZE-1:0] vld_ff;
   logic [GRID_SIZE-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   // row valid bits: a row never written since reset or clear reads as dead
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // row storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read with its valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== design/lgs_row_rule.sv =====
// next-generation rule for one full row from the rows above, at and below
`default_nettype none

module lgs_row_rule #(
   parameter int unsigned GRID_SIZE = 64
) (
   input  wire logic [GRID_SIZE-1:0] up_row,
   input  wire logic [GRID_SIZE-1:0] cur_row,
   input  wire logic [GRID_SIZE-1:0] dn_row,
   output logic      [GRID_SIZE-1:0] nxt_row
);
   import lgs_pkg::*;

   // one lane per column, neighbors wrap at the row ends
   for (genvar c = 0; c < GRID_SIZE; c++) begin : g_lane
      localparam int unsigned LF = (c + GRID_SIZE - 1) % GRID_SIZE;
      localparam int unsigned RT = (c + 1) % GRID_SIZE;

      logic [NBR_CNT_W-1:0] nbr_cnt;

      assign nbr_cnt = NBR_CNT_W'(up_row[LF]) + NBR_CNT_W'(up_row[c])
                     + NBR_CNT_W'(up_row[RT]) + NBR_CNT_W'(cur_row[LF])
                     + NBR_CNT_W'(cur_row[RT]) + NBR_CNT_W'(dn_row[LF])
                     + NBR_CNT_W'(dn_row[c]) + NBR_CNT_W'(dn_row[RT]);

      // birth on three, survival on two or three
      assign nxt_row[c] = (nbr_cnt == BIRTH_COUNT)
                        || (cur_row[c] && (nbr_cnt == KEEP_COUNT));
   end

endmodule

`default_nettype wire
